FILE: rtl/pexi_pkg.sv
package pexi_pkg;

    localparam int KNOTS   = 1024;
    localparam int IDX_W   = $clog2(KNOTS);
    localparam int DATA_W  = 32;
    localparam int SEG_W   = 12;
    localparam int LOGF    = 30;             // fraction bits of log2 and exponent
    localparam int LOG_W   = 35;             // Q5.30 log2
    localparam int DIFF_W  = 36;             // signed log difference
    localparam int PROD_W  = 68;             // |dl| * |d|
    localparam int QUO_W   = 36;             // quotient bits before the cap
    localparam int EXP_W   = 38;             // signed exponent, Q.30
    localparam int IN_W    = 152;
    localparam int OUT_W   = 32;

    // pipeline positions in the valid chain
    localparam int ST_LOG0 = 1;
    localparam int ST_DIV0 = ST_LOG0 + LOGF + 4;
    localparam int ST_EXP0 = ST_DIV0 + QUO_W + 1;
    localparam int NSTAGE  = ST_EXP0 + LOGF + 2;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.31, each the integer square root of the one before
    function automatic logic [31:0] exp_const(input int k);
        logic [63:0] c;
        c = 64'd1 << 32;
        for (int j = 1; j <= k; j++)
            c = isqrt64(c << 31);
        return c[31:0];
    endfunction

endpackage

FILE: rtl/pexi_ram.sv
module pexi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/piecewise_exponential_interpolator_unit.sv
// Throughput: one word per cycle while the output register is not stalled;
// loads and queries mix freely. The rate is set by the fully pipelined log2 /
// divide / exp2 datapath and one read port per knot memory (y is held twice so
// y[i] and y[i+1] read together).
// Reset: asynchronous, active low; clears the valid chain and sets
// segment_count to 1. Knot memories are not cleared and must be loaded first.
module piecewise_exponential_interpolator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // knot_index, knot_x, knot_y, knot_width, segment, query_point, 2 pad bits
    input  logic [pexi_pkg::IN_W-1:0]    s_axis_tdata,
    // op
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // value
    output logic [pexi_pkg::OUT_W-1:0]   m_axis_tdata,
    // saturated
    output logic                         m_axis_tuser,
    input  logic                         cfg_we,
    input  logic [pexi_pkg::IDX_W-1:0]   cfg_wdata
);

    localparam int LOGF = pexi_pkg::LOGF;
    localparam int QW   = pexi_pkg::QUO_W;

    // ---------------------------------------------------------------- input side
    logic                          adv;
    logic                          in_acc;
    logic                          in_query;
    logic                          in_load;
    logic [pexi_pkg::IDX_W-1:0]    in_knot_index;
    logic [31:0]                   in_knot_x;
    logic [31:0]                   in_knot_y;
    logic [31:0]                   in_knot_width;
    logic [pexi_pkg::SEG_W-1:0]    in_segment;
    logic [31:0]                   in_query_point;

    logic [pexi_pkg::IDX_W-1:0]    seg_count_reg;
    logic [pexi_pkg::IDX_W-1:0]    nseg;
    logic                          seg_big;
    logic [pexi_pkg::IDX_W-1:0]    rd_idx;
    logic [pexi_pkg::IDX_W-1:0]    rd_idx_hi;

    logic [pexi_pkg::NSTAGE-1:0]   vld_reg;

    // whole pipeline moves together; the output register is the only stall point
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;
    assign in_query      = in_acc && (pexi_pkg::op_t'(s_axis_tuser) == pexi_pkg::OP_QUERY);
    assign in_load       = in_acc && (pexi_pkg::op_t'(s_axis_tuser) == pexi_pkg::OP_LOAD);

    assign in_knot_index  = s_axis_tdata[9:0];
    assign in_knot_x      = s_axis_tdata[41:10];
    assign in_knot_y      = s_axis_tdata[73:42];
    assign in_knot_width  = s_axis_tdata[105:74];
    assign in_segment     = s_axis_tdata[117:106];
    assign in_query_point = s_axis_tdata[149:118];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_count_reg <= pexi_pkg::IDX_W'(1);
        else if (cfg_we)
            seg_count_reg <= cfg_wdata;
    end

    // clamp segment to [0, nseg-1]; out-of-range points extrapolate
    assign nseg    = (seg_count_reg == '0) ? pexi_pkg::IDX_W'(1) : seg_count_reg;
    assign seg_big = {1'b0, in_segment[10:0]} >= {2'b00, nseg};

    always_comb
    begin
        if (in_segment[11])
            rd_idx = '0;
        else if (seg_big)
            rd_idx = nseg - pexi_pkg::IDX_W'(1);
        else
            rd_idx = in_segment[pexi_pkg::IDX_W-1:0];
    end

    assign rd_idx_hi = rd_idx + pexi_pkg::IDX_W'(1);

    // ---------------------------------------------------------------- knot memories
    // A load writes on its accept edge; a later query reads on its own, so no
    // forwarding is needed.
    logic [31:0] x_rd;
    logic [31:0] y0_rd;
    logic [31:0] y1_rd;
    logic [31:0] w_rd;

    pexi_ram #(.WIDTH(32), .DEPTH(pexi_pkg::KNOTS)) u_ram_x (
        .clk(clk), .we(in_load), .waddr(in_knot_index), .wdata(in_knot_x),
        .re(adv), .raddr(rd_idx), .rdata(x_rd)
    );

    pexi_ram #(.WIDTH(32), .DEPTH(pexi_pkg::KNOTS)) u_ram_y0 (
        .clk(clk), .we(in_load), .waddr(in_knot_index), .wdata(in_knot_y),
        .re(adv), .raddr(rd_idx), .rdata(y0_rd)
    );

    pexi_ram #(.WIDTH(32), .DEPTH(pexi_pkg::KNOTS)) u_ram_y1 (
        .clk(clk), .we(in_load), .waddr(in_knot_index), .wdata(in_knot_y),
        .re(adv), .raddr(rd_idx_hi), .rdata(y1_rd)
    );

    pexi_ram #(.WIDTH(32), .DEPTH(pexi_pkg::KNOTS)) u_ram_w (
        .clk(clk), .we(in_load), .waddr(in_knot_index), .wdata(in_knot_width),
        .re(adv), .raddr(rd_idx), .rdata(w_rd)
    );

    logic [31:0] p_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            p_rd_reg <= in_query_point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[pexi_pkg::NSTAGE-2:0], in_query};
    end

    // ---------------------------------------------------------------- normalise
    function automatic logic [4:0] top_bit(input logic [31:0] v);
        logic [4:0] e;
        e = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                e = 5'(i);
        end
        return e;
    endfunction

    logic [31:0]                  lg_m0_reg [0:LOGF];
    logic [31:0]                  lg_m1_reg [0:LOGF];
    logic [pexi_pkg::LOG_W-1:0]   lg_l0_reg [0:LOGF];
    logic [pexi_pkg::LOG_W-1:0]   lg_l1_reg [0:LOGF];
    logic signed [32:0]           lg_d_reg  [0:LOGF];
    logic [31:0]                  lg_w_reg  [0:LOGF];

    logic [31:0] y0n;
    logic [31:0] y1n;
    logic [4:0]  e0;
    logic [4:0]  e1;
    logic [31:0] m0_next;
    logic [31:0] m1_next;
    logic signed [32:0] d_next;
    logic [31:0] w_next;

    always_comb
    begin
        y0n     = (y0_rd == '0) ? 32'd1 : y0_rd;
        y1n     = (y1_rd == '0) ? 32'd1 : y1_rd;
        e0      = top_bit(y0n);
        e1      = top_bit(y1n);
        m0_next = y0n << (5'd31 - e0);
        m1_next = y1n << (5'd31 - e1);
        d_next  = $signed({p_rd_reg[31], p_rd_reg}) - $signed({x_rd[31], x_rd});
        w_next  = (w_rd == '0) ? 32'd1 : w_rd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_m0_reg[0] <= m0_next;
            lg_m1_reg[0] <= m1_next;
            lg_l0_reg[0] <= {e0, {LOGF{1'b0}}};
            lg_l1_reg[0] <= {e1, {LOGF{1'b0}}};
            lg_d_reg[0]  <= d_next;
            lg_w_reg[0]  <= w_next;
        end
    end

    // ---------------------------------------------------------------- log2, one bit a stage
    // square the Q1.31 mantissa; a carry into bit 32 is the next fraction bit
    for (genvar k = 1; k <= LOGF; k++)
    begin : g_log
        logic [63:0]                sq0;
        logic [63:0]                sq1;
        logic [32:0]                t0;
        logic [32:0]                t1;
        logic [31:0]                m0_next_k;
        logic [31:0]                m1_next_k;
        logic [pexi_pkg::LOG_W-1:0] l0_next_k;
        logic [pexi_pkg::LOG_W-1:0] l1_next_k;

        always_comb
        begin
            sq0 = lg_m0_reg[k-1] * lg_m0_reg[k-1];
            sq1 = lg_m1_reg[k-1] * lg_m1_reg[k-1];
            t0  = sq0[63:31];
            t1  = sq1[63:31];
            if (t0[32])
            begin
                m0_next_k = t0[32:1];
                l0_next_k = lg_l0_reg[k-1] | (pexi_pkg::LOG_W'(1) << (LOGF - k));
            end
            else
            begin
                m0_next_k = t0[31:0];
                l0_next_k = lg_l0_reg[k-1];
            end
            if (t1[32])
            begin
                m1_next_k = t1[32:1];
                l1_next_k = lg_l1_reg[k-1] | (pexi_pkg::LOG_W'(1) << (LOGF - k));
            end
            else
            begin
                m1_next_k = t1[31:0];
                l1_next_k = lg_l1_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lg_m0_reg[k] <= m0_next_k;
                lg_m1_reg[k] <= m1_next_k;
                lg_l0_reg[k] <= l0_next_k;
                lg_l1_reg[k] <= l1_next_k;
                lg_d_reg[k]  <= lg_d_reg[k-1];
                lg_w_reg[k]  <= lg_w_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- signs and magnitudes
    logic signed [pexi_pkg::DIFF_W-1:0] dl;
    logic [pexi_pkg::DIFF_W-1:0]        dl_neg;
    logic [32:0]                        d_neg;
    logic [34:0]                        a_next;
    logic [32:0]                        b_next;
    logic                               neg_next;

    logic [34:0]                  df_a_reg;
    logic [32:0]                  df_b_reg;
    logic                         df_neg_reg;
    logic [pexi_pkg::LOG_W-1:0]   df_li_reg;
    logic [31:0]                  df_w_reg;

    always_comb
    begin
        dl       = $signed({1'b0, lg_l1_reg[LOGF]}) - $signed({1'b0, lg_l0_reg[LOGF]});
        dl_neg   = -dl;
        d_neg    = -lg_d_reg[LOGF];
        a_next   = dl[pexi_pkg::DIFF_W-1] ? dl_neg[34:0] : dl[34:0];
        b_next   = lg_d_reg[LOGF][32] ? d_neg : lg_d_reg[LOGF];
        neg_next = dl[pexi_pkg::DIFF_W-1] ^ lg_d_reg[LOGF][32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            df_a_reg   <= a_next;
            df_b_reg   <= b_next;
            df_neg_reg <= neg_next;
            df_li_reg  <= lg_l0_reg[LOGF];
            df_w_reg   <= lg_w_reg[LOGF];
        end
    end

    // ---------------------------------------------------------------- product in two halves
    logic [50:0]                  mu_lo_reg;
    logic [49:0]                  mu_hi_reg;
    logic                         mu_neg_reg;
    logic [pexi_pkg::LOG_W-1:0]   mu_li_reg;
    logic [31:0]                  mu_w_reg;
    logic [50:0]                  pp_lo_next;
    logic [49:0]                  pp_hi_next;

    assign pp_lo_next = df_a_reg[17:0] * df_b_reg;
    assign pp_hi_next = df_a_reg[34:18] * df_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_lo_reg  <= pp_lo_next;
            mu_hi_reg  <= pp_hi_next;
            mu_neg_reg <= df_neg_reg;
            mu_li_reg  <= df_li_reg;
            mu_w_reg   <= df_w_reg;
        end
    end

    logic [pexi_pkg::PROD_W-1:0]  sm_p_reg;
    logic                         sm_neg_reg;
    logic [pexi_pkg::LOG_W-1:0]   sm_li_reg;
    logic [31:0]                  sm_w_reg;
    logic [pexi_pkg::PROD_W-1:0]  p_next;

    assign p_next = pexi_pkg::PROD_W'(mu_lo_reg) + (pexi_pkg::PROD_W'(mu_hi_reg) << 18);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_p_reg   <= p_next;
            sm_neg_reg <= mu_neg_reg;
            sm_li_reg  <= mu_li_reg;
            sm_w_reg   <= mu_w_reg;
        end
    end

    // ---------------------------------------------------------------- divide, one bit a stage
    // quotient caps at 2^36: known up front once P >> 36 reaches w
    logic [31:0]                  dv_rem_reg [0:QW];
    logic [QW-1:0]                dv_low_reg [0:QW];
    logic [QW-1:0]                dv_q_reg   [0:QW];
    logic                         dv_cap_reg [0:QW];
    logic                         dv_neg_reg [0:QW];
    logic [pexi_pkg::LOG_W-1:0]   dv_li_reg  [0:QW];
    logic [31:0]                  dv_w_reg   [0:QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0] <= sm_p_reg[pexi_pkg::PROD_W-1:QW];
            dv_low_reg[0] <= sm_p_reg[QW-1:0];
            dv_q_reg[0]   <= '0;
            dv_cap_reg[0] <= sm_p_reg[pexi_pkg::PROD_W-1:QW] >= sm_w_reg;
            dv_neg_reg[0] <= sm_neg_reg;
            dv_li_reg[0]  <= sm_li_reg;
            dv_w_reg[0]   <= sm_w_reg;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        logic [32:0]   r;
        logic [32:0]   r_sub;
        logic          qb;
        logic [31:0]   rem_next;

        always_comb
        begin
            r        = {dv_rem_reg[j-1], dv_low_reg[j-1][QW-j]};
            r_sub    = r - {1'b0, dv_w_reg[j-1]};
            qb       = r >= {1'b0, dv_w_reg[j-1]};
            rem_next = qb ? r_sub[31:0] : r[31:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[j] <= rem_next;
                dv_low_reg[j] <= dv_low_reg[j-1];
                dv_q_reg[j]   <= {dv_q_reg[j-1][QW-2:0], qb};
                dv_cap_reg[j] <= dv_cap_reg[j-1];
                dv_neg_reg[j] <= dv_neg_reg[j-1];
                dv_li_reg[j]  <= dv_li_reg[j-1];
                dv_w_reg[j]   <= dv_w_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------- exponent
    logic [QW:0]                         qc;
    logic signed [pexi_pkg::EXP_W-1:0]   e_next;
    logic                                sat_next;

    always_comb
    begin
        qc = dv_cap_reg[QW] ? ((QW+1)'(1) << QW) : {1'b0, dv_q_reg[QW]};
        if (dv_neg_reg[QW])
            e_next = $signed({3'b000, dv_li_reg[QW]}) - $signed({1'b0, qc});
        else
            e_next = $signed({3'b000, dv_li_reg[QW]}) + $signed({1'b0, qc});
        // E >= 32.0
        sat_next = !e_next[pexi_pkg::EXP_W-1] && (e_next[36] || e_next[35]);
    end

    logic [31:0]         ex_m_reg   [0:LOGF];
    logic [LOGF-1:0]     ex_f_reg   [0:LOGF];
    logic signed [7:0]   ex_n_reg   [0:LOGF];
    logic                ex_sat_reg [0:LOGF];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_m_reg[0]   <= 32'd1 << 31;
            ex_f_reg[0]   <= e_next[LOGF-1:0];
            ex_n_reg[0]   <= e_next[pexi_pkg::EXP_W-1:LOGF];
            ex_sat_reg[0] <= sat_next;
        end
    end

    // ---------------------------------------------------------------- exp2 of fraction
    for (genvar k = 1; k <= LOGF; k++)
    begin : g_exp
        localparam logic [31:0] CK = pexi_pkg::exp_const(k);
        logic [63:0] prod;
        logic [31:0] m_next_k;

        always_comb
        begin
            prod     = ex_m_reg[k-1] * CK;
            m_next_k = ex_f_reg[k-1][LOGF-k] ? prod[62:31] : ex_m_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_m_reg[k]   <= m_next_k;
                ex_f_reg[k]   <= ex_f_reg[k-1];
                ex_n_reg[k]   <= ex_n_reg[k-1];
                ex_sat_reg[k] <= ex_sat_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- scale and round
    logic signed [7:0] n_fin;
    logic [7:0]        sh_full;
    logic [5:0]        sh;
    logic [32:0]       rsum;
    logic [32:0]       rshift;
    logic [31:0]       val_next;
    logic              satf_next;
    logic [31:0]       out_val_reg;
    logic              out_sat_reg;

    always_comb
    begin
        n_fin     = ex_n_reg[LOGF];
        sh_full   = 8'd31 - n_fin;
        sh        = sh_full[5:0];
        rsum      = {1'b0, ex_m_reg[LOGF]} + (33'd1 << (sh - 6'd1));
        rshift    = rsum >> sh;
        satf_next = ex_sat_reg[LOGF];
        if (ex_sat_reg[LOGF])
            val_next = '1;
        else if (n_fin == 8'sd31)
            val_next = ex_m_reg[LOGF];
        else if (n_fin < -8'sd1)
            val_next = '0;          // rounds away to nothing
        else
            val_next = rshift[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_val_reg <= val_next;
            out_sat_reg <= satf_next;
        end
    end

    assign m_axis_tvalid = vld_reg[pexi_pkg::NSTAGE-1];
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tuser  = out_sat_reg;

    // ---------------------------------------------------------------- checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_query |-> rd_idx < nseg)
        else $error("clamped segment beyond segment count");

    a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[pexi_pkg::ST_LOG0 + LOGF] |-> lg_m0_reg[LOGF][31] && lg_m1_reg[LOGF][31])
        else $error("log2 mantissa lost normalisation");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[pexi_pkg::ST_DIV0] && !dv_cap_reg[0] |-> dv_rem_reg[0] < dv_w_reg[0])
        else $error("divider start remainder not below width");

    a_exp_norm: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[pexi_pkg::ST_EXP0 + LOGF] |-> ex_m_reg[LOGF][31])
        else $error("exp2 mantissa below one");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '1)
        else $error("saturated word without full-scale value");

endmodule

FILE: sim/tb_piecewise_exponential_interpolator_unit.sv
`timescale 1ns / 100ps

module tb_piecewise_exponential_interpolator_unit;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 130;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [pexi_pkg::IN_W-1:0]     s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [pexi_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                          m_axis_tuser;
    logic                          cfg_we;
    logic [pexi_pkg::IDX_W-1:0]    cfg_wdata;

    typedef struct packed
    {
        logic [31:0] value;
        logic        saturated;
    } interp_t;

    // Knot table shadow, segment count and the queue of expected values.
    class interp_scoreboard;
        logic [31:0] x_tab[pexi_pkg::KNOTS];
        logic [31:0] y_tab[pexi_pkg::KNOTS];
        logic [31:0] w_tab[pexi_pkg::KNOTS];
        int unsigned seg_count;
        interp_t     pending[$];
        int          errors;
        int          n_sat;
        int          n_zero;
        int          n_loads;
        int          n_queries;

        function new();
            seg_count = 1;
        endfunction

        // log2 of a raw value, Q5.30
        function automatic logic [63:0] log2_raw(logic [31:0] y_in);
            logic [63:0] mant;
            logic [63:0] l;
            logic [31:0] y;
            int          e;
            y = (y_in == 0) ? 32'd1 : y_in;
            e = 31;
            while (!y[e])
                e--;
            mant = 64'(y) << (31 - e);
            l = 64'(e) << pexi_pkg::LOGF;
            for (int k = 1; k <= pexi_pkg::LOGF; k++)
            begin
                mant = (mant * mant) >> 31;
                if (mant >= (64'd1 << 32))
                begin
                    l[pexi_pkg::LOGF - k] = 1'b1;
                    mant = mant >> 1;
                end
            end
            return l;
        endfunction

        function automatic logic [63:0] root_int(logic [63:0] v_in);
            logic [63:0] v;
            logic [63:0] r;
            logic [63:0] b;
            v = v_in;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // 2^(f/2^30), Q1.31
        function automatic logic [63:0] pow2_frac(logic [63:0] f);
            logic [63:0] c;
            logic [63:0] m;
            c = 64'd1 << 32;
            m = 64'd1 << 31;
            for (int k = 1; k <= pexi_pkg::LOGF; k++)
            begin
                c = root_int(c << 31);
                if (f[pexi_pkg::LOGF - k])
                    m = (m * c) >> 31;
            end
            return m;
        endfunction

        function void note_word(pexi_pkg::op_t op, logic [pexi_pkg::IN_W-1:0] d);
            logic [9:0]        k;
            logic signed [11:0] seg12;
            logic signed [63:0] p;
            logic signed [63:0] x;
            logic signed [63:0] dx;
            logic signed [63:0] dl;
            logic signed [63:0] e;
            logic [63:0]       li;
            logic [63:0]       l1;
            logic [63:0]       w;
            logic [127:0]      prod;
            logic [127:0]      q;
            logic [63:0]       eo;
            logic [63:0]       m;
            logic [63:0]       val;
            int                n;
            int                sh;
            int unsigned       nseg;
            int unsigned       idx;
            interp_t           r;
            k = d[9:0];
            if (op == pexi_pkg::OP_LOAD)
            begin
                x_tab[k] = d[41:10];
                y_tab[k] = d[73:42];
                w_tab[k] = d[105:74];
                n_loads++;
                return;
            end
            n_queries++;
            seg12 = d[117:106];
            p = 64'(signed'(d[149:118]));
            nseg = (seg_count < 1) ? 1 : seg_count;
            if (seg12 < 0)
                idx = 0;
            else if (seg12 >= nseg)
                idx = nseg - 1;
            else
                idx = seg12;
            x = 64'(signed'(x_tab[idx]));
            li = log2_raw(y_tab[idx]);
            l1 = log2_raw(y_tab[idx + 1]);
            w = (w_tab[idx] == 0) ? 64'd1 : 64'(w_tab[idx]);
            dx = p - x;
            dl = signed'(l1) - signed'(li);
            prod = 128'(dl < 0 ? -dl : dl) * 128'(dx < 0 ? -dx : dx);
            q = prod / w;
            if (q > (128'd1 << 36))
                q = 128'd1 << 36;
            e = ((dl < 0) != (dx < 0)) ? signed'(li) - signed'(q[63:0])
                                       : signed'(li) + signed'(q[63:0]);
            if (e >= (64'sd32 <<< pexi_pkg::LOGF))
                r = '{32'hFFFF_FFFF, 1'b1};
            else
            begin
                eo = e + (64'sd64 <<< pexi_pkg::LOGF);
                n = int'(eo >> pexi_pkg::LOGF) - 64;
                m = pow2_frac(eo & ((64'd1 << pexi_pkg::LOGF) - 1));
                sh = 31 - n;
                if (sh >= 64)
                    val = 0;
                else if (sh == 0)
                    val = m;
                else
                    val = (m + (64'd1 << (sh - 1))) >> sh;
                if (val > 64'hFFFF_FFFF)
                    r = '{32'hFFFF_FFFF, 1'b1};
                else
                    r = '{val[31:0], 1'b0};
            end
            if (r.saturated)
                n_sat++;
            if (r.value == 0)
                n_zero++;
            pending.push_back(r);
        endfunction

        function void check_word(logic [31:0] value, logic saturated);
            interp_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected output word value=%h saturated=%b", value, saturated);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (value !== exp_r.value)
            begin
                $error("value: expected %h, got %h", exp_r.value, value);
                errors++;
            end
            if (saturated !== exp_r.saturated)
            begin
                $error("saturated: expected %b, got %b", exp_r.saturated, saturated);
                errors++;
            end
        endfunction
    endclass

    interp_scoreboard sb;
    int               cycle_count;
    bit               sink_stall_en;

    piecewise_exponential_interpolator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog: the worst case is well under this even with full stalls.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, sampled at the rising edge.
    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_n = sink_stall_en ? $urandom_range(0, 16) : 0;
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n)
                    @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    // One word on the input, preceded by a random gap when idling is on.
    // tvalid stays up after the word so that the next one can follow at once;
    // callers that pause drop it through input_idle.
    task automatic send_word(pexi_pkg::op_t op, logic [9:0] k, logic [31:0] x,
                             logic [31:0] y, logic [31:0] w, logic [11:0] seg,
                             logic [31:0] p, bit gaps);
        int wait_n;
        wait_n = gaps ? $urandom_range(0, 16) : 0;
        if (wait_n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_n)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, p, seg, w, y, x, k};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(op, {2'b00, p, seg, w, y, x, k});
        @(negedge clk);
    endtask

    task automatic input_idle();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic load_knot(logic [9:0] k, logic [31:0] x, logic [31:0] y,
                             logic [31:0] w, bit gaps);
        send_word(pexi_pkg::OP_LOAD, k, x, y, w, 12'($urandom), $urandom, gaps);
    endtask

    task automatic query(logic [11:0] seg, logic [31:0] p, bit gaps);
        send_word(pexi_pkg::OP_QUERY, 10'($urandom), $urandom, $urandom, $urandom,
                  seg, p, gaps);
    endtask

    // Wait for every outstanding result, then the pipeline depth, so that a
    // trailing load has surely landed before the next register write.
    task automatic drain();
        input_idle();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_segments(int unsigned n);
        cfg_we    <= 1'b1;
        cfg_wdata <= pexi_pkg::IDX_W'(n);
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.seg_count = n;
    endtask

    function automatic logic [31:0] rand_y();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(1, 255));
            1:       return $urandom | 32'h8000_0000;
            default: return 32'h0001_0000 + 32'($urandom_range(0, 32'h3_0000));
        endcase
    endfunction

    function automatic logic [31:0] rand_w();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(1, 16));
            default: return 32'($urandom_range(32'h0001_0000, 32'h0010_0000));
        endcase
    endfunction

    // Load knots 0..n with ascending x and random y / width.
    task automatic load_table(int unsigned n, bit gaps);
        logic [31:0] xpos;
        xpos = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        for (int unsigned k = 0; k <= n; k++)
        begin
            load_knot(10'(k), xpos, rand_y(), rand_w(), gaps);
            xpos = xpos + 32'($urandom_range(1, 32'h0004_0000));
        end
    endtask

    task automatic random_query(int unsigned n, bit gaps);
        logic [11:0] seg;
        logic [31:0] p;
        int signed   base;
        case ($urandom_range(0, 7))
            0:       seg = 12'($urandom);                        // any index
            1:       seg = 12'hFFF;                              // underflow
            2:       seg = 12'(n + $urandom_range(0, 3));        // overflow
            default: seg = 12'($urandom_range(0, n - 1));
        endcase
        if ($urandom_range(0, 3) == 0)
            p = $urandom;
        else
        begin
            base = signed'(sb.x_tab[seg < n ? seg : n - 1]);
            p = 32'(base + $urandom_range(0, 32'h0008_0000) - 32'h0002_0000);
        end
        query(seg, p, gaps);
    endtask

    initial
    begin
        int unsigned n;
        bit          gaps;
        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pexi_pkg::OP_LOAD;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        sink_stall_en = 1'b0;
        rst_n         = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, zero y and width, clamping both ways,
        // overflow to saturation and underflow to zero, with reset count 1.
        load_knot(10'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        load_knot(10'd1, 32'h7FFF_FFFF, 32'd1, 32'd0, 1'b0);
        query(12'd0, 32'h8000_0000, 1'b0);
        query(12'd0, 32'h7FFF_FFFF, 1'b0);
        query(12'h800, 32'h0000_0000, 1'b0);
        query(12'h7FF, 32'h8000_0000, 1'b0);
        load_knot(10'd0, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        load_knot(10'd1, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b0);
        query(12'd0, 32'h0000_8000, 1'b0);
        query(12'hFFF, 32'h7FFF_FFFF, 1'b0);        // extrapolates to saturation
        query(12'd1024, 32'h8000_0000, 1'b0);       // decays to zero
        load_knot(10'd0, 32'hFFFF_0000, 32'd0, 32'd0, 1'b0);
        query(12'd0, 32'h0000_0000, 1'b0);
        query(12'd5, 32'hFFFF_FFFF, 1'b0);
        drain();

        // Largest segment count: knots at the top end of the table, queries
        // in range, clamped from above and clamped to the first segment.
        set_segments(1023);
        for (int k = 1018; k <= 1023; k++)
            load_knot(10'(k), 32'((k - 1020) * 32'h0001_0000), rand_y(), rand_w(), 1'b0);
        query(12'd1018, 32'hFFFE_8000, 1'b0);
        query(12'd1020, 32'h0000_4000, 1'b0);
        query(12'd1021, 32'h0001_2000, 1'b0);
        query(12'd1022, 32'h0002_8000, 1'b0);
        query(12'd1023, 32'h0012_3456, 1'b0);
        query(12'h7FF, 32'h0003_0000, 1'b0);
        query(12'hFFF, 32'h0000_1000, 1'b0);
        drain();

        // Count zero behaves as one segment.
        set_segments(0);
        query(12'd0, 32'h0000_1234, 1'b0);
        query(12'd3, 32'hFFFF_1234, 1'b0);
        drain();

        // Random phases with small tables; stalls switched on and off.
        for (int phase = 0; phase < 14; phase++)
        begin
            n = (phase % 4 == 0) ? 1 : $urandom_range(2, 12);
            gaps = (phase % 3 != 2);
            sink_stall_en = (phase % 4 != 3);
            set_segments(n);
            load_table(n, gaps);
            for (int i = 0; i < 58; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_knot(10'($urandom_range(0, n)), $urandom, rand_y(), rand_w(), gaps);
                else
                    random_query(n, gaps);
                // sender holds off until the result side has caught up
                if (i == 30)
                begin
                    input_idle();
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        sink_stall_en = 1'b1;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("covered %0d loads and %0d queries (%0d saturated, %0d rounded to zero)",
                 sb.n_loads, sb.n_queries, sb.n_sat, sb.n_zero);
        $display("segment counts 0, 1, up to 12 and 1023; clamping both ways exercised");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pexi_pkg.sv
rtl/pexi_ram.sv
rtl/piecewise_exponential_interpolator_unit.sv
sim/tb_piecewise_exponential_interpolator_unit.sv
